/* design/rmq_pkg.sv */
// Shared types, widths and helpers for the rotation matrix to quaternion pipeline.
// No dependencies; every other design file refers to this package by scoped names.
package rmq_pkg;

    localparam int DW = 16;
    localparam int FB = 14;

    // Signed trace width. It holds the four-element trace and the Shepperd sum.
    localparam int TW = DW + 3;
    localparam int RW0 = TW - 1 + FB;
    localparam int RW = RW0 + (RW0 % 2);
    localparam int SW = RW / 2;
    localparam int NW = DW + 1;
    localparam int DVW = NW + FB + 1;
    localparam int DSW = SW + 1;

    localparam logic signed [TW-1:0] ONE_T = TW'(1) << FB;
    localparam logic [DVW-1:0] MAX_POS = (DVW'(1) << (DW - 1)) - DVW'(1);

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [NW-1:0] num_t;
    typedef logic [1:0] comp_idx_t;

    localparam comp_idx_t COMP_X = 2'd0;
    localparam comp_idx_t COMP_Y = 2'd1;
    localparam comp_idx_t COMP_Z = 2'd2;
    localparam comp_idx_t COMP_W = 2'd3;

    // The slot marks the component that comes from the square root.
    typedef struct packed {
        comp_idx_t slot;
        logic      degen;
    } side_t;

    function automatic word_t sat_mag(input logic neg, input logic [DVW-1:0] mag);
        word_t res;
        if (!neg) begin
            res = (mag > MAX_POS) ? word_t'(MAX_POS[DW-1:0]) : word_t'(mag[DW-1:0]);
        end
        else if (mag > MAX_POS + DVW'(1)) begin
            res = word_t'(MAX_POS[DW-1:0] + DW'(1));
        end
        else begin
            res = word_t'(-mag[DW-1:0]);
        end
        return res;
    endfunction

endpackage

/* design/rotation_matrix_to_quaternion.sv */
// In order: front end, square root, divider setup, dividers, output reg (16-bit Q2.14).
// Throughput: one transaction per cycle; busy is always low and done cannot be held off.
// The depth is set by the square-root pipeline (one root bit per stage) and the three
// dividers (one quotient bit per stage). Reset is asynchronous, active low, and clears
// only the valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rmq_pkg::word_t m00,
    input  rmq_pkg::word_t m01,
    input  rmq_pkg::word_t m02,
    input  rmq_pkg::word_t m10,
    input  rmq_pkg::word_t m11,
    input  rmq_pkg::word_t m12,
    input  rmq_pkg::word_t m20,
    input  rmq_pkg::word_t m21,
    input  rmq_pkg::word_t m22,
    input  rmq_pkg::word_t m33,
    output logic           done,
    output rmq_pkg::word_t qx,
    output rmq_pkg::word_t qy,
    output rmq_pkg::word_t qz,
    output rmq_pkg::word_t qw,
    output logic           degenerate
);

    localparam int N = rmq_pkg::DVW;

    logic                   fr_valid;
    logic [rmq_pkg::RW-1:0] fr_rad;
    rmq_pkg::num_t [2:0]    fr_num;
    rmq_pkg::side_t         fr_side;

    logic                   sq_valid;
    logic [rmq_pkg::SW-1:0] sq_root;
    rmq_pkg::num_t [2:0]    sq_num;
    rmq_pkg::side_t         sq_side;

    logic                    p_valid_reg;
    rmq_pkg::side_t          p_side_reg;
    logic [rmq_pkg::SW-1:0]  p_sqc_reg, p_sqc_next;
    logic [2:0]              p_neg_reg, p_neg_next;
    logic [N-1:0]            p_dvd_reg [3];
    logic [N-1:0]            p_dvd_next [3];
    logic [rmq_pkg::DSW-1:0] p_dsr_reg, p_dsr_next;

    logic [N-1:0]            quo [3];

    logic [N-1:0]            dl_valid_reg;
    rmq_pkg::side_t          dl_side_reg [N];
    logic [rmq_pkg::SW-1:0]  dl_sqc_reg  [N];
    logic [2:0]              dl_neg_reg  [N];

    logic                    done_reg;
    logic                    degen_reg;
    rmq_pkg::word_t [3:0]    q_reg, q_next;

    assign busy = 1'b0;

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22),
        .m33       (m33),
        .out_valid (fr_valid),
        .radicand  (fr_rad),
        .num       (fr_num),
        .side      (fr_side)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .radicand  (fr_rad),
        .in_num    (fr_num),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_num   (sq_num),
        .out_side  (sq_side)
    );

    // Dividend is |num| scaled by one plus half the divisor, so the quotient rounds
    // to nearest with ties away from zero.
    always_comb begin
        logic [rmq_pkg::SW:0] sq_inc;
        logic [rmq_pkg::NW-1:0] mag;
        sq_inc = {1'b0, sq_root} + (rmq_pkg::SW + 1)'(1);
        p_sqc_next = sq_inc[rmq_pkg::SW:1];
        p_dsr_next = {sq_root, 1'b0};
        for (int c = 0; c < 3; c++) begin
            p_neg_next[c] = sq_num[c][rmq_pkg::NW-1];
            mag = p_neg_next[c] ? rmq_pkg::NW'(-sq_num[c]) : rmq_pkg::NW'(sq_num[c]);
            p_dvd_next[c] = N'({mag, {rmq_pkg::FB{1'b0}}}) + N'(sq_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p_valid_reg <= 1'b0;
        end
        else begin
            p_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk) begin
        p_side_reg <= sq_side;
        p_sqc_reg  <= p_sqc_next;
        p_neg_reg  <= p_neg_next;
        p_dsr_reg  <= p_dsr_next;
        for (int c = 0; c < 3; c++) begin
            p_dvd_reg[c] <= p_dvd_next[c];
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_div
        rmq_div u_div (
            .clk      (clk),
            .dividend (p_dvd_reg[c]),
            .divisor  (p_dsr_reg),
            .quotient (quo[c])
        );
    end

    for (genvar s = 0; s < N; s++) begin : g_delay
        if (s == 0) begin : g_first
            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    dl_valid_reg[s] <= 1'b0;
                end
                else begin
                    dl_valid_reg[s] <= p_valid_reg;
                end
            end
            always_ff @(posedge clk) begin
                dl_side_reg[s] <= p_side_reg;
                dl_sqc_reg[s]  <= p_sqc_reg;
                dl_neg_reg[s]  <= p_neg_reg;
            end
        end
        else begin : g_rest
            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    dl_valid_reg[s] <= 1'b0;
                end
                else begin
                    dl_valid_reg[s] <= dl_valid_reg[s-1];
                end
            end
            always_ff @(posedge clk) begin
                dl_side_reg[s] <= dl_side_reg[s-1];
                dl_sqc_reg[s]  <= dl_sqc_reg[s-1];
                dl_neg_reg[s]  <= dl_neg_reg[s-1];
            end
        end
    end

    // Divider c serves component c, except that the divider at the root's slot
    // holds the w quotient when the root component is a vector component.
    always_comb begin
        rmq_pkg::side_t sd;
        logic [2:0]     ng;
        logic [N-1:0]   wq;
        logic           wn;
        sd = dl_side_reg[N-1];
        ng = dl_neg_reg[N-1];
        case (sd.slot)
            rmq_pkg::COMP_Y: begin
                wq = quo[1];
                wn = ng[1];
            end
            rmq_pkg::COMP_Z: begin
                wq = quo[2];
                wn = ng[2];
            end
            default: begin
                wq = quo[0];
                wn = ng[0];
            end
        endcase
        for (int c = 0; c < 4; c++) begin
            if (sd.degen) begin
                q_next[c] = '0;
            end
            else if (sd.slot == rmq_pkg::comp_idx_t'(c)) begin
                q_next[c] = rmq_pkg::sat_mag(1'b0, N'(dl_sqc_reg[N-1]));
            end
            else if (c == 3) begin
                q_next[c] = rmq_pkg::sat_mag(wn, wq);
            end
            else begin
                q_next[c] = rmq_pkg::sat_mag(ng[c], quo[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= dl_valid_reg[N-1];
        end
    end

    always_ff @(posedge clk) begin
        q_reg     <= q_next;
        degen_reg <= dl_side_reg[N-1].degen;
    end

    assign done       = done_reg;
    assign qx         = q_reg[0];
    assign qy         = q_reg[1];
    assign qz         = q_reg[2];
    assign qw         = q_reg[3];
    assign degenerate = degen_reg;

endmodule

/* design/rmq_front.sv */
// Front end: trace, index choice, radicand and the three numerators, two register stages.
// Depends on rmq_pkg.
module rmq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  rmq_pkg::word_t                m00,
    input  rmq_pkg::word_t                m01,
    input  rmq_pkg::word_t                m02,
    input  rmq_pkg::word_t                m10,
    input  rmq_pkg::word_t                m11,
    input  rmq_pkg::word_t                m12,
    input  rmq_pkg::word_t                m20,
    input  rmq_pkg::word_t                m21,
    input  rmq_pkg::word_t                m22,
    input  rmq_pkg::word_t                m33,
    output logic                          out_valid,
    output logic [rmq_pkg::RW-1:0]        radicand,
    output rmq_pkg::num_t [2:0]           num,
    output rmq_pkg::side_t                side
);

    logic                          s1_valid_reg;
    logic signed [rmq_pkg::TW-1:0] trace_reg, trace_next;
    rmq_pkg::word_t                d00_reg, d11_reg, d22_reg;
    rmq_pkg::comp_idx_t            idx_reg, idx_next;
    rmq_pkg::num_t [2:0]           diff_reg, diff_next;
    rmq_pkg::num_t                 s01_reg, s02_reg, s12_reg;
    rmq_pkg::num_t                 s01_next, s02_next, s12_next;

    logic                          s2_valid_reg;
    logic [rmq_pkg::RW-1:0]        rad_reg, rad_next;
    rmq_pkg::num_t [2:0]           num_reg, num_next;
    rmq_pkg::side_t                side_reg, side_next;

    rmq_pkg::word_t                pick01;
    rmq_pkg::word_t                mii, mjj, mkk;
    logic signed [rmq_pkg::TW-1:0] tshep, tsel;
    logic                          trace_ok;

    always_comb begin
        pick01 = (m00 <= m11) ? m11 : m00;
        if (m22 > pick01) begin
            idx_next = rmq_pkg::COMP_Z;
        end
        else if (m00 <= m11) begin
            idx_next = rmq_pkg::COMP_Y;
        end
        else begin
            idx_next = rmq_pkg::COMP_X;
        end
        trace_next = rmq_pkg::TW'(m00) + rmq_pkg::TW'(m11) + rmq_pkg::TW'(m22)
                   + rmq_pkg::TW'(m33);
        diff_next[0] = rmq_pkg::NW'(m12) - rmq_pkg::NW'(m21);
        diff_next[1] = rmq_pkg::NW'(m20) - rmq_pkg::NW'(m02);
        diff_next[2] = rmq_pkg::NW'(m01) - rmq_pkg::NW'(m10);
        s01_next = rmq_pkg::NW'(m01) + rmq_pkg::NW'(m10);
        s02_next = rmq_pkg::NW'(m02) + rmq_pkg::NW'(m20);
        s12_next = rmq_pkg::NW'(m12) + rmq_pkg::NW'(m21);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        trace_reg <= trace_next;
        d00_reg   <= m00;
        d11_reg   <= m11;
        d22_reg   <= m22;
        idx_reg   <= idx_next;
        diff_reg  <= diff_next;
        s01_reg   <= s01_next;
        s02_reg   <= s02_next;
        s12_reg   <= s12_next;
    end

    // Below a trace of one, each vector component off the chosen index uses the symmetric
    // pair sum with the chosen row, and the chosen slot carries the w numerator.
    always_comb begin
        case (idx_reg)
            rmq_pkg::COMP_Y: begin
                mii = d11_reg;
                mjj = d22_reg;
                mkk = d00_reg;
                num_next[0] = s01_reg;
                num_next[1] = diff_reg[1];
                num_next[2] = s12_reg;
            end
            rmq_pkg::COMP_Z: begin
                mii = d22_reg;
                mjj = d00_reg;
                mkk = d11_reg;
                num_next[0] = s02_reg;
                num_next[1] = s12_reg;
                num_next[2] = diff_reg[2];
            end
            default: begin
                mii = d00_reg;
                mjj = d11_reg;
                mkk = d22_reg;
                num_next[0] = diff_reg[0];
                num_next[1] = s01_reg;
                num_next[2] = s02_reg;
            end
        endcase
        tshep = rmq_pkg::TW'(mii) - rmq_pkg::TW'(mjj) - rmq_pkg::TW'(mkk) + rmq_pkg::ONE_T;
        trace_ok = (trace_reg >= rmq_pkg::ONE_T);
        if (trace_ok) begin
            num_next = diff_reg;
            tsel = trace_reg;
            side_next.slot = rmq_pkg::COMP_W;
        end
        else begin
            tsel = tshep;
            side_next.slot = idx_reg;
        end
        side_next.degen = !trace_ok && (tshep <= 0);
        if (side_next.degen) begin
            rad_next = '0;
        end
        else begin
            rad_next = rmq_pkg::RW'(tsel[rmq_pkg::TW-2:0]) << rmq_pkg::FB;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end
        else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        rad_reg  <= rad_next;
        num_reg  <= num_next;
        side_reg <= side_next;
    end

    assign out_valid = s2_valid_reg;
    assign radicand  = rad_reg;
    assign num       = num_reg;
    assign side      = side_reg;

endmodule

/* design/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with the sideband carried along.
// Depends on rmq_pkg.
module rmq_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [rmq_pkg::RW-1:0] radicand,
    input  rmq_pkg::num_t [2:0]    in_num,
    input  rmq_pkg::side_t         in_side,
    output logic                   out_valid,
    output logic [rmq_pkg::SW-1:0] root,
    output rmq_pkg::num_t [2:0]    out_num,
    output rmq_pkg::side_t         out_side
);

    localparam int S = rmq_pkg::SW;

    logic [S-1:0]                   v_reg;
    logic [S+1:0]                   rem_reg  [S];
    logic [S-1:0]                   root_reg [S];
    logic [rmq_pkg::RW-1:0]         rad_reg  [S];
    rmq_pkg::num_t [2:0]            num_reg  [S];
    rmq_pkg::side_t                 side_reg [S];

    for (genvar s = 0; s < S; s++) begin : g_stage
        logic                   v_prev;
        logic [S+1:0]           rem_prev, rem_cur, trial, rem_next;
        logic [S-1:0]           root_prev, root_next;
        logic [rmq_pkg::RW-1:0] rad_prev;
        rmq_pkg::num_t [2:0]    num_prev;
        rmq_pkg::side_t         side_prev;

        if (s == 0) begin : g_first
            always_comb begin
                v_prev    = in_valid;
                rem_prev  = '0;
                root_prev = '0;
                rad_prev  = radicand;
                num_prev  = in_num;
                side_prev = in_side;
            end
        end
        else begin : g_rest
            always_comb begin
                v_prev    = v_reg[s-1];
                rem_prev  = rem_reg[s-1];
                root_prev = root_reg[s-1];
                rad_prev  = rad_reg[s-1];
                num_prev  = num_reg[s-1];
                side_prev = side_reg[s-1];
            end
        end

        always_comb begin
            rem_cur = {rem_prev[S-1:0], rad_prev[rmq_pkg::RW-1 -: 2]};
            trial   = {root_prev, 2'b01};
            if (rem_cur >= trial) begin
                rem_next  = rem_cur - trial;
                root_next = {root_prev[S-2:0], 1'b1};
            end
            else begin
                rem_next  = rem_cur;
                root_next = {root_prev[S-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg[s] <= 1'b0;
            end
            else begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk) begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            rad_reg[s]  <= rad_prev << 2;
            num_reg[s]  <= num_prev;
            side_reg[s] <= side_prev;
        end
    end

    assign out_valid = v_reg[S-1];
    assign root      = root_reg[S-1];
    assign out_num   = num_reg[S-1];
    assign out_side  = side_reg[S-1];

endmodule

/* design/rmq_div.sv */
// Pipelined restoring divider, one quotient bit per stage, data path only.
// Depends on rmq_pkg.
module rmq_div (
    input  logic                    clk,
    input  logic [rmq_pkg::DVW-1:0] dividend,
    input  logic [rmq_pkg::DSW-1:0] divisor,
    output logic [rmq_pkg::DVW-1:0] quotient
);

    localparam int N = rmq_pkg::DVW;
    localparam int D = rmq_pkg::DSW;

    logic [D-1:0] rem_reg [N];
    logic [N-1:0] dvd_reg [N];
    logic [N-1:0] quo_reg [N];
    logic [D-1:0] dsr_reg [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [D-1:0] rem_prev, dsr_prev;
        logic [N-1:0] dvd_prev, quo_prev;
        logic [D:0]   rem_cur, rem_next;
        logic         qbit;

        if (s == 0) begin : g_first
            always_comb begin
                rem_prev = '0;
                dvd_prev = dividend;
                quo_prev = '0;
                dsr_prev = divisor;
            end
        end
        else begin : g_rest
            always_comb begin
                rem_prev = rem_reg[s-1];
                dvd_prev = dvd_reg[s-1];
                quo_prev = quo_reg[s-1];
                dsr_prev = dsr_reg[s-1];
            end
        end

        always_comb begin
            rem_cur = {rem_prev, dvd_prev[N-1]};
            qbit    = (rem_cur >= {1'b0, dsr_prev});
            rem_next = qbit ? (rem_cur - {1'b0, dsr_prev}) : rem_cur;
        end

        always_ff @(posedge clk) begin
            rem_reg[s] <= rem_next[D-1:0];
            dvd_reg[s] <= dvd_prev << 1;
            quo_reg[s] <= {quo_prev[N-2:0], qbit};
            dsr_reg[s] <= dsr_prev;
        end
    end

    assign quotient = quo_reg[N-1];

endmodule
